// ===== rtl/qtg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtg_pkg
// Types, codes and micro-op tables shared by the quintic trajectory block.
// ----------------------------------------------------------------------------
package qtg_pkg;

    localparam int COEF_FRAC_BITS = 32;
    localparam int WORD_BITS      = 256;
    localparam int AMT_BITS       = 9;

    typedef logic [WORD_BITS-1:0] t_word;

    // item kinds
    localparam logic [1:0] KIND_SOLVE = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [2:0] NUM_COEF = 3'd6;

    typedef enum logic [3:0] {
        OP_LDIN, OP_ADD, OP_SUB, OP_SHL, OP_MUL, OP_DIV, OP_RSH,
        OP_SAT64, OP_SAT32, OP_END
    } t_op;

    typedef enum logic [1:0] {BS_REG, BS_IMM, BS_COEF} t_bsel;

    typedef enum logic [3:0] {
        LD_SPOS, LD_SVEL, LD_SACC, LD_EPOS, LD_EVEL, LD_EACC,
        LD_DUR, LD_TIME, LD_ONE, LD_ZERO
    } t_ldsel;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_EXEC, ST_WAIT} t_state;
    typedef enum logic {MD_SOLVE, MD_EVAL} t_mode;
    typedef enum logic [3:0] {
        EP_PRO, EP_CLR, EP_MC, EP_MF, EP_SH, EP_AC, EP_RND, EP_SAT, EP_DONE
    } t_eph;

    typedef struct packed {
        t_op               op;
        logic [4:0]        dst;
        logic [4:0]        sa;
        logic [4:0]        sb;
        t_bsel             bsel;
        logic signed [15:0] imm;
    } t_uop;

    typedef struct packed {
        logic                start;
        t_op                 op;
        logic [AMT_BITS-1:0] amt;
    } t_alu_req;

    // scratch registers, solve
    localparam logic [4:0] R_X0 = 5'd0,  R_V0 = 5'd1,  R_A0 = 5'd2,  R_XT = 5'd3;
    localparam logic [4:0] R_VT = 5'd4,  R_AT = 5'd5,  R_R  = 5'd6,  R_R2 = 5'd7;
    localparam logic [4:0] R_R3 = 5'd8,  R_B0 = 5'd9,  R_B1 = 5'd10, R_B2 = 5'd11;
    localparam logic [4:0] R_P  = 5'd12, R_Q  = 5'd13, R_N3 = 5'd14, R_N4 = 5'd15;
    localparam logic [4:0] R_N5 = 5'd16, R_T1 = 5'd17, R_T2 = 5'd18;
    // scratch registers, evaluate (powers of t sit at their exponent)
    localparam logic [4:0] E_P0 = 5'd0, E_P1 = 5'd1, E_P2 = 5'd2, E_P3 = 5'd3;
    localparam logic [4:0] E_P4 = 5'd4, E_P5 = 5'd5, E_ACC = 5'd6, E_TMP = 5'd7;

    function automatic t_uop mk(t_op op, logic [4:0] dst, logic [4:0] sa,
                                logic [4:0] sb, t_bsel bs, int imm);
        t_uop u;
        u.op   = op;
        u.dst  = dst;
        u.sa   = sa;
        u.sb   = sb;
        u.bsel = bs;
        u.imm  = 16'(imm);
        return u;
    endfunction

    function automatic logic is_alu(t_op op);
        logic r;
        case (op) inside
            OP_ADD, OP_SUB, OP_SHL, OP_MUL, OP_DIV, OP_RSH: r = 1'b1;
            default:                                        r = 1'b0;
        endcase
        return r;
    endfunction

    // boundary solve program
    function automatic t_uop solve_uop(logic [5:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(OP_LDIN, R_X0, R_X0, R_X0, BS_REG, int'(LD_SPOS));
            6'd1:  u = mk(OP_LDIN, R_V0, R_X0, R_X0, BS_REG, int'(LD_SVEL));
            6'd2:  u = mk(OP_LDIN, R_A0, R_X0, R_X0, BS_REG, int'(LD_SACC));
            6'd3:  u = mk(OP_LDIN, R_XT, R_X0, R_X0, BS_REG, int'(LD_EPOS));
            6'd4:  u = mk(OP_LDIN, R_VT, R_X0, R_X0, BS_REG, int'(LD_EVEL));
            6'd5:  u = mk(OP_LDIN, R_AT, R_X0, R_X0, BS_REG, int'(LD_EACC));
            6'd6:  u = mk(OP_LDIN, R_R,  R_X0, R_X0, BS_REG, int'(LD_DUR));
            6'd7:  u = mk(OP_MUL,  R_R2, R_R,  R_R,  BS_REG, 0);
            6'd8:  u = mk(OP_MUL,  R_R3, R_R2, R_R,  BS_REG, 0);
            // b0
            6'd9:  u = mk(OP_SUB,  R_T1, R_XT, R_X0, BS_REG, 0);
            6'd10: u = mk(OP_SHL,  R_T1, R_T1, R_T1, BS_REG, 33);
            6'd11: u = mk(OP_MUL,  R_T2, R_V0, R_R,  BS_REG, 0);
            6'd12: u = mk(OP_SHL,  R_T2, R_T2, R_T2, BS_REG, 17);
            6'd13: u = mk(OP_SUB,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd14: u = mk(OP_MUL,  R_T2, R_A0, R_R2, BS_REG, 0);
            6'd15: u = mk(OP_SUB,  R_B0, R_T1, R_T2, BS_REG, 0);
            // b1, b2
            6'd16: u = mk(OP_SUB,  R_T1, R_VT, R_V0, BS_REG, 0);
            6'd17: u = mk(OP_SHL,  R_T1, R_T1, R_T1, BS_REG, 16);
            6'd18: u = mk(OP_MUL,  R_T2, R_A0, R_R,  BS_REG, 0);
            6'd19: u = mk(OP_SUB,  R_B1, R_T1, R_T2, BS_REG, 0);
            6'd20: u = mk(OP_SUB,  R_B2, R_AT, R_A0, BS_REG, 0);
            6'd21: u = mk(OP_MUL,  R_P,  R_B1, R_R,  BS_REG, 0);
            6'd22: u = mk(OP_MUL,  R_T1, R_B2, R_R2, BS_REG, 0);
            6'd23: u = mk(OP_SHL,  R_Q,  R_T1, R_T1, BS_REG, 1);
            // numerators
            6'd24: u = mk(OP_MUL,  R_T1, R_B0, R_B0, BS_IMM, 20);
            6'd25: u = mk(OP_SHL,  R_T2, R_P,  R_P,  BS_REG, 4);
            6'd26: u = mk(OP_SUB,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd27: u = mk(OP_ADD,  R_N3, R_T1, R_Q,  BS_REG, 0);
            6'd28: u = mk(OP_MUL,  R_T1, R_B0, R_B0, BS_IMM, -15);
            6'd29: u = mk(OP_MUL,  R_T2, R_P,  R_P,  BS_IMM, 14);
            6'd30: u = mk(OP_ADD,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd31: u = mk(OP_SUB,  R_N4, R_T1, R_Q,  BS_REG, 0);
            6'd32: u = mk(OP_MUL,  R_T1, R_B0, R_B0, BS_IMM, 12);
            6'd33: u = mk(OP_MUL,  R_T2, R_P,  R_P,  BS_IMM, 12);
            6'd34: u = mk(OP_SUB,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd35: u = mk(OP_ADD,  R_N5, R_T1, R_Q,  BS_REG, 0);
            // c0..c2
            6'd36: u = mk(OP_SHL,  R_T1, R_X0, R_X0, BS_REG, COEF_FRAC_BITS);
            6'd37: u = mk(OP_RSH,  R_T1, R_T1, R_T1, BS_REG, 16);
            6'd38: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 0);
            6'd39: u = mk(OP_SHL,  R_T1, R_V0, R_V0, BS_REG, COEF_FRAC_BITS);
            6'd40: u = mk(OP_RSH,  R_T1, R_T1, R_T1, BS_REG, 16);
            6'd41: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 1);
            6'd42: u = mk(OP_SHL,  R_T1, R_A0, R_A0, BS_REG, COEF_FRAC_BITS);
            6'd43: u = mk(OP_RSH,  R_T1, R_T1, R_T1, BS_REG, 17);
            6'd44: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 2);
            // c3..c5
            6'd45: u = mk(OP_SHL,  R_T2, R_R3, R_R3, BS_REG, 2);
            6'd46: u = mk(OP_SHL,  R_T1, R_N3, R_N3, BS_REG, COEF_FRAC_BITS);
            6'd47: u = mk(OP_DIV,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd48: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 3);
            6'd49: u = mk(OP_MUL,  R_T2, R_R3, R_R,  BS_REG, 0);
            6'd50: u = mk(OP_SHL,  R_T1, R_N4, R_N4, BS_REG, COEF_FRAC_BITS + 15);
            6'd51: u = mk(OP_DIV,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd52: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 4);
            6'd53: u = mk(OP_MUL,  R_T2, R_R3, R_R2, BS_REG, 0);
            6'd54: u = mk(OP_SHL,  R_T1, R_N5, R_N5, BS_REG, COEF_FRAC_BITS + 30);
            6'd55: u = mk(OP_DIV,  R_T1, R_T1, R_T2, BS_REG, 0);
            6'd56: u = mk(OP_SAT64, R_T1, R_T1, R_T1, BS_REG, 5);
            default: u = mk(OP_END, R_X0, R_X0, R_X0, BS_REG, 0);
        endcase
        return u;
    endfunction

    // k! / (k-d)!
    function automatic int fct(logic [2:0] d, logic [2:0] k);
        int f;
        case ({d, k})
            {3'd1, 3'd2}: f = 2;
            {3'd1, 3'd3}: f = 3;
            {3'd1, 3'd4}: f = 4;
            {3'd1, 3'd5}: f = 5;
            {3'd2, 3'd2}: f = 2;
            {3'd2, 3'd3}: f = 6;
            {3'd2, 3'd4}: f = 12;
            {3'd2, 3'd5}: f = 20;
            {3'd3, 3'd3}: f = 6;
            {3'd3, 3'd4}: f = 24;
            {3'd3, 3'd5}: f = 60;
            {3'd4, 3'd4}: f = 24;
            {3'd4, 3'd5}: f = 120;
            default:      f = 1;
        endcase
        return f;
    endfunction

    // evaluate program: prologue, then for each derivative d a term loop over k
    function automatic t_uop eval_uop(t_eph ph, logic [5:0] pc, logic [2:0] d,
                                      logic [2:0] k);
        t_uop       u;
        logic [2:0] m;
        m = k - d;
        unique case (ph)
            EP_PRO: begin
                case (pc)
                    6'd0:    u = mk(OP_LDIN, E_P0, E_P0, E_P0, BS_REG, int'(LD_ONE));
                    6'd1:    u = mk(OP_LDIN, E_P1, E_P0, E_P0, BS_REG, int'(LD_TIME));
                    6'd2:    u = mk(OP_MUL, E_P2, E_P1, E_P1, BS_REG, 0);
                    6'd3:    u = mk(OP_MUL, E_P3, E_P2, E_P1, BS_REG, 0);
                    6'd4:    u = mk(OP_MUL, E_P4, E_P3, E_P1, BS_REG, 0);
                    default: u = mk(OP_MUL, E_P5, E_P4, E_P1, BS_REG, 0);
                endcase
            end
            EP_CLR:  u = mk(OP_LDIN, E_ACC, E_P0, E_P0, BS_REG, int'(LD_ZERO));
            EP_MC:   u = mk(OP_MUL, E_TMP, {2'b00, m}, E_P0, BS_COEF, int'(k));
            EP_MF:   u = mk(OP_MUL, E_TMP, E_TMP, E_TMP, BS_IMM, fct(d, k));
            EP_SH:   u = mk(OP_SHL, E_TMP, E_TMP, E_TMP, BS_REG, (5 - int'(m)) * 16);
            EP_AC:   u = mk(OP_ADD, E_ACC, E_ACC, E_TMP, BS_REG, 0);
            EP_RND:  u = mk(OP_RSH, E_TMP, E_ACC, E_ACC, BS_REG, COEF_FRAC_BITS + 64);
            EP_SAT:  u = mk(OP_SAT32, E_TMP, E_TMP, E_TMP, BS_REG, int'(d));
            default: u = mk(OP_END, E_P0, E_P0, E_P0, BS_REG, 0);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/qtg_alu.sv =====
// ----------------------------------------------------------------------------
// qtg_alu
// Shared 256-bit arithmetic unit: add, subtract, shift, limb-serial multiply,
// bit-serial rounded divide and rounded power-of-two shift.
// ----------------------------------------------------------------------------
module qtg_alu
    import qtg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    input  t_word    i_a,
    input  t_word    i_b,
    output logic     o_done,
    output t_word    o_res
);

    logic                r_run;
    logic                r_done;
    t_op                 r_op;
    logic [AMT_BITS-1:0] r_amt;
    logic [2:0]          r_i;
    logic [2:0]          r_j;
    logic [8:0]          r_cnt;
    logic                r_neg;
    t_word               r_acc;
    t_word               r_mag;
    t_word               r_rem;
    t_word               r_q;
    t_word               r_res;

    logic [63:0] pp;
    logic [2:0]  pp_pos;
    t_word       mac;
    t_word       abs_a;
    logic [WORD_BITS:0] rem_sh;
    logic        ge;
    t_word       rem_nx;
    t_word       rsh_q;

    always_comb begin
        pp     = 64'(i_a[32*r_i +: 32]) * 64'(i_b[32*r_j +: 32]);
        pp_pos = r_i + r_j;
        mac    = r_acc + (t_word'(pp) << {pp_pos, 5'b00000});
        abs_a  = i_a[WORD_BITS-1] ? (~i_a + t_word'(1)) : i_a;
        rem_sh = {r_rem, r_mag[WORD_BITS-1]};
        ge     = rem_sh >= {1'b0, i_b};
        rem_nx = ge ? t_word'(rem_sh - {1'b0, i_b}) : t_word'(rem_sh);
        rsh_q  = r_mag >> r_amt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op  <= i_req.op;
                r_amt <= i_req.amt;
                r_i   <= '0;
                r_j   <= '0;
                r_cnt <= '0;
                r_acc <= '0;
                r_rem <= '0;
                r_q   <= '0;
                r_neg <= i_a[WORD_BITS-1];
                case (i_req.op)
                    OP_ADD: begin
                        r_res  <= i_a + i_b;
                        r_done <= 1'b1;
                    end
                    OP_SUB: begin
                        r_res  <= i_a - i_b;
                        r_done <= 1'b1;
                    end
                    OP_SHL: begin
                        r_res  <= i_a << i_req.amt;
                        r_done <= 1'b1;
                    end
                    OP_DIV: begin
                        r_mag <= abs_a + (i_b >> 1);
                        r_run <= 1'b1;
                    end
                    OP_RSH: begin
                        r_mag <= abs_a + (t_word'(1) << (i_req.amt - AMT_BITS'(1)));
                        r_run <= 1'b1;
                    end
                    default: r_run <= 1'b1;
                endcase
            end else if (r_run) begin
                case (r_op)
                    OP_MUL: begin
                        r_acc <= mac;
                        if (pp_pos == 3'd7) begin
                            if (r_i == 3'd7) begin
                                r_res  <= mac;
                                r_done <= 1'b1;
                                r_run  <= 1'b0;
                            end else begin
                                r_i <= r_i + 3'd1;
                                r_j <= '0;
                            end
                        end else begin
                            r_j <= r_j + 3'd1;
                        end
                    end
                    OP_DIV: begin
                        if (r_cnt[8]) begin
                            r_res  <= r_neg ? (~r_q + t_word'(1)) : r_q;
                            r_done <= 1'b1;
                            r_run  <= 1'b0;
                        end else begin
                            r_rem <= rem_nx;
                            r_q   <= {r_q[WORD_BITS-2:0], ge};
                            r_mag <= {r_mag[WORD_BITS-2:0], 1'b0};
                            r_cnt <= r_cnt + 9'd1;
                        end
                    end
                    default: begin
                        r_res  <= r_neg ? (~rsh_q + t_word'(1)) : rsh_q;
                        r_done <= 1'b1;
                        r_run  <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/quintic_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_generator
// Six-coefficient quintic trajectory: solve from boundary conditions, load a
// coefficient, or evaluate position and four derivatives at a time.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  command   start & !busy        i_kind, boundary values, i_duration,
//                                 i_coef_index, i_coef_value, i_sample_time
//  result    o_valid (one cycle)  o_position .. o_snap, o_clipped
//
//  A load beat writes its coefficient as it is taken. Solve runs a micro-op
//  program (14 multiplies of 36 limb steps, 3 divides of 256 bit steps).
//  Evaluate is bound by 38 multiplies on the one 32x32 multiplier. Solve
//  with zero duration and kind 3 are dropped at once.
//  Reset: synchronous, clears the coefficients and the sequencer.
//  The result strobe is not back-pressured; a new command may be taken in
//  the cycle the strobe is high.
//
module quintic_trajectory_generator
    import qtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_start_pos,
    input  logic signed [31:0] i_start_vel,
    input  logic signed [31:0] i_start_acc,
    input  logic signed [31:0] i_end_pos,
    input  logic signed [31:0] i_end_vel,
    input  logic signed [31:0] i_end_acc,
    input  logic [23:0]        i_duration,
    input  logic [2:0]         i_coef_index,
    input  logic signed [63:0] i_coef_value,
    input  logic [23:0]        i_sample_time,
    output logic               o_valid,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_acceleration,
    output logic signed [31:0] o_jerk,
    output logic signed [31:0] o_snap,
    output logic               o_clipped
);

    // sequencer state
    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    t_eph       r_ph, n_ph;
    logic [5:0] r_pc, n_pc;
    logic [2:0] r_d, n_d;
    logic [2:0] r_k, n_k;
    logic       r_valid, n_valid;
    logic       r_clip, n_clip;

    // latched command payload
    logic [31:0] r_xin [6];
    logic [23:0] r_dur;
    logic [23:0] r_time;

    logic [63:0] r_coef [6];
    logic [31:0] r_out [5];

    // scratch register file, two registered read ports
    t_word r_rf [32];
    t_word r_rda;
    t_word r_rdb;

    logic     accept;
    t_uop     uop;
    t_word    b_word;
    t_word    ld_val;
    t_alu_req alu_req;
    logic     alu_done;
    t_word    alu_res;
    logic     step;
    logic     exec_local;
    logic     rf_we;
    t_word    rf_wd;
    logic     sat64_ok;
    logic [63:0] sat64_val;
    logic     sat32_ok;
    logic [31:0] sat32_val;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (r_mode == MD_SOLVE) uop = solve_uop(r_pc);
        else                    uop = eval_uop(r_ph, r_pc, r_d, r_k);
    end

    // operand B and input load selection
    always_comb begin
        case (uop.bsel)
            BS_IMM:  b_word = {{(WORD_BITS-16){uop.imm[15]}}, uop.imm};
            BS_COEF: b_word = {{(WORD_BITS-64){r_coef[uop.imm[2:0]][63]}},
                               r_coef[uop.imm[2:0]]};
            default: b_word = r_rdb;
        endcase
        case (t_ldsel'(uop.imm[3:0]))
            LD_SPOS: ld_val = {{(WORD_BITS-32){r_xin[0][31]}}, r_xin[0]};
            LD_SVEL: ld_val = {{(WORD_BITS-32){r_xin[1][31]}}, r_xin[1]};
            LD_SACC: ld_val = {{(WORD_BITS-32){r_xin[2][31]}}, r_xin[2]};
            LD_EPOS: ld_val = {{(WORD_BITS-32){r_xin[3][31]}}, r_xin[3]};
            LD_EVEL: ld_val = {{(WORD_BITS-32){r_xin[4][31]}}, r_xin[4]};
            LD_EACC: ld_val = {{(WORD_BITS-32){r_xin[5][31]}}, r_xin[5]};
            LD_DUR:  ld_val = t_word'(r_dur);
            LD_TIME: ld_val = t_word'(r_time);
            LD_ONE:  ld_val = t_word'(1);
            default: ld_val = '0;
        endcase
    end

    // saturation of operand A
    always_comb begin
        sat64_ok  = (&r_rda[WORD_BITS-1:63]) || !(|r_rda[WORD_BITS-1:63]);
        sat64_val = sat64_ok ? r_rda[63:0]
                  : (r_rda[WORD_BITS-1] ? 64'h8000_0000_0000_0000
                                        : 64'h7fff_ffff_ffff_ffff);
        sat32_ok  = (&r_rda[WORD_BITS-1:31]) || !(|r_rda[WORD_BITS-1:31]);
        sat32_val = sat32_ok ? r_rda[31:0]
                  : (r_rda[WORD_BITS-1] ? 32'h8000_0000 : 32'h7fff_ffff);
    end

    assign exec_local    = (r_state == ST_EXEC) && !is_alu(uop.op);
    assign alu_req.start = (r_state == ST_EXEC) && is_alu(uop.op);
    assign alu_req.op    = uop.op;
    assign alu_req.amt   = uop.imm[AMT_BITS-1:0];

    assign rf_we = (exec_local && uop.op == OP_LDIN) || (r_state == ST_WAIT && alu_done);
    assign rf_wd = (r_state == ST_WAIT) ? alu_res : ld_val;

    qtg_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_rda),
        .i_b     (b_word),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // next state and program advance
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ph    = r_ph;
        n_pc    = r_pc;
        n_d     = r_d;
        n_k     = r_k;
        n_valid = 1'b0;
        n_clip  = r_clip;
        step    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_SOLVE && i_duration != 24'd0) begin
                        n_state = ST_ISSUE;
                        n_mode  = MD_SOLVE;
                        n_pc    = '0;
                    end else if (i_kind == KIND_EVAL) begin
                        n_state = ST_ISSUE;
                        n_mode  = MD_EVAL;
                        n_ph    = EP_PRO;
                        n_pc    = '0;
                        n_clip  = 1'b0;
                    end
                end
            end
            ST_ISSUE: n_state = ST_EXEC;
            ST_EXEC: begin
                if (is_alu(uop.op)) begin
                    n_state = ST_WAIT;
                end else if (uop.op == OP_END) begin
                    n_state = ST_IDLE;
                    n_valid = (r_mode == MD_EVAL);
                end else begin
                    n_state = ST_ISSUE;
                    step    = 1'b1;
                    if (uop.op == OP_SAT32) n_clip = r_clip | !sat32_ok;
                end
            end
            default: begin
                if (alu_done) begin
                    n_state = ST_ISSUE;
                    step    = 1'b1;
                end
            end
        endcase

        if (step) begin
            if (r_mode == MD_SOLVE) begin
                n_pc = r_pc + 6'd1;
            end else begin
                case (r_ph)
                    EP_PRO: begin
                        if (r_pc == 6'd5) begin
                            n_ph = EP_CLR;
                            n_d  = '0;
                        end else begin
                            n_pc = r_pc + 6'd1;
                        end
                    end
                    EP_CLR: begin
                        n_k  = r_d;
                        n_ph = EP_MC;
                    end
                    EP_MC:  n_ph = (r_d == 3'd0) ? EP_SH : EP_MF;
                    EP_MF:  n_ph = EP_SH;
                    EP_SH:  n_ph = EP_AC;
                    EP_AC: begin
                        if (r_k == 3'd5) begin
                            n_ph = EP_RND;
                        end else begin
                            n_k  = r_k + 3'd1;
                            n_ph = EP_MC;
                        end
                    end
                    EP_RND: n_ph = EP_SAT;
                    EP_SAT: begin
                        if (r_d == 3'd4) begin
                            n_ph = EP_DONE;
                        end else begin
                            n_d  = r_d + 3'd1;
                            n_ph = EP_CLR;
                        end
                    end
                    default: n_ph = EP_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MD_SOLVE;
            r_ph    <= EP_PRO;
            r_pc    <= '0;
            r_d     <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
            r_clip  <= 1'b0;
            for (int i = 0; i < 6; i++) r_coef[i] <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_ph    <= n_ph;
            r_pc    <= n_pc;
            r_d     <= n_d;
            r_k     <= n_k;
            r_valid <= n_valid;
            r_clip  <= n_clip;
            if (accept && i_kind == KIND_LOAD && i_coef_index < NUM_COEF) begin
                r_coef[i_coef_index] <= i_coef_value;
            end
            if (exec_local && uop.op == OP_SAT64) begin
                r_coef[uop.imm[2:0]] <= sat64_val;
            end
        end
    end

    // payload: command latch and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xin[0] <= i_start_pos;
            r_xin[1] <= i_start_vel;
            r_xin[2] <= i_start_acc;
            r_xin[3] <= i_end_pos;
            r_xin[4] <= i_end_vel;
            r_xin[5] <= i_end_acc;
            r_dur    <= i_duration;
            r_time   <= i_sample_time;
        end
        if (exec_local && uop.op == OP_SAT32) begin
            r_out[uop.imm[2:0]] <= sat32_val;
        end
    end

    // scratch file
    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[uop.dst] <= rf_wd;
        if (r_state == ST_ISSUE) begin
            r_rda <= r_rf[uop.sa];
            r_rdb <= r_rf[uop.sb];
        end
    end

    assign o_valid        = r_valid;
    assign o_position     = r_out[0];
    assign o_velocity     = r_out[1];
    assign o_acceleration = r_out[2];
    assign o_jerk         = r_out[3];
    assign o_snap         = r_out[4];
    assign o_clipped      = r_clip;

`ifndef SYNTH
    // result beat is a single-cycle strobe
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // unit completes only while the sequencer waits on it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == ST_WAIT))
        else $error("arithmetic unit done outside wait");

    // results come only from an evaluate run
    a_valid_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_mode) == MD_EVAL && $past(r_state) == ST_EXEC))
        else $error("result strobe without evaluate");
`endif

endmodule

// ===== dv/quintic_trajectory_generator_tb.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_tb
// Drives solve, load, evaluate and unused-kind beats into the trajectory block, predicts
// every evaluate result with exact wide arithmetic, and checks each strobed
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module quintic_trajectory_generator_tb;
    import qtg_pkg::*;

    typedef logic signed [255:0] t_wide;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] spos, svel, sacc, epos, evel, eacc;
        logic [23:0]        dur;
        logic [2:0]         idx;
        logic signed [63:0] val;
        logic [23:0]        tsamp;
    } t_cmd;

    typedef struct {
        logic signed [31:0] pos, vel, acc, jrk, snp;
        logic               clip;
    } t_kin;

    localparam int WATCHDOG = 40000;

    logic               i_clk, i_rst_n, start, busy;
    logic [1:0]         i_kind;
    logic signed [31:0] i_start_pos, i_start_vel, i_start_acc;
    logic signed [31:0] i_end_pos, i_end_vel, i_end_acc;
    logic [23:0]        i_duration, i_sample_time;
    logic [2:0]         i_coef_index;
    logic signed [63:0] i_coef_value;
    logic               o_valid, o_clipped;
    logic signed [31:0] o_position, o_velocity, o_acceleration, o_jerk, o_snap;

    quintic_trajectory_generator dut (.*);

    t_cmd               cmd_q[$];
    t_kin               kin_q[$];
    t_cmd               cur;
    logic signed [63:0] coef[6];
    int                 n_beats, n_solve, n_load, n_eval, n_clip, n_bad, idle_pct;
    int                 quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- wide arithmetic predictor ----------------
    // round to nearest, ties away from zero; den is positive
    function automatic t_wide div_round(t_wide num, t_wide den);
        logic [255:0] mag, q;
        logic         neg;
        neg = num[255];
        mag = neg ? -num : num;
        mag = mag + (den >> 1);
        q   = mag / den;
        return neg ? t_wide'(-q) : t_wide'(q);
    endfunction

    function automatic logic [63:0] clamp(t_wide a, int bits, inout logic clip);
        t_wide       hi;
        logic [63:0] top;
        hi  = a >>> (bits - 1);
        top = 64'd1 << (bits - 1);
        if (hi != '0 && hi != '1) begin
            clip = 1'b1;
            return a[255] ? top : top - 64'd1;
        end
        return a[63:0];
    endfunction

    task automatic solve_coefs(t_cmd c);
        t_wide x0, v0, a0, xt, vt, at, r, r2, r3, b0, b1, b2, p, q, n3, n4, n5;
        logic  dummy;
        dummy = 1'b0;
        if (c.dur == '0) return;  // zero duration leaves coefficients alone
        x0 = c.spos; v0 = c.svel; a0 = c.sacc;
        xt = c.epos; vt = c.evel; at = c.eacc;
        r  = {232'd0, c.dur};
        r2 = r * r;
        r3 = r2 * r;
        b0 = ((xt - x0) <<< 33) - ((v0 * r) <<< 17) - a0 * r2;
        b1 = ((vt - v0) <<< 16) - a0 * r;
        b2 = at - a0;
        p  = b1 * r;
        q  = (b2 * r2) * 2;
        n3 = b0 * 20 - p * 16 + q;
        n4 = b0 * (-15) + p * 14 - q;
        n5 = b0 * 12 - p * 12 + q;
        coef[0] = clamp(div_round(x0 <<< COEF_FRAC_BITS, t_wide'(1) <<< 16), 64, dummy);
        coef[1] = clamp(div_round(v0 <<< COEF_FRAC_BITS, t_wide'(1) <<< 16), 64, dummy);
        coef[2] = clamp(div_round(a0 <<< COEF_FRAC_BITS, t_wide'(1) <<< 17), 64, dummy);
        coef[3] = clamp(div_round(n3 <<< COEF_FRAC_BITS, r3 * 4), 64, dummy);
        coef[4] = clamp(div_round(n4 <<< (COEF_FRAC_BITS + 15), r3 * r), 64, dummy);
        coef[5] = clamp(div_round(n5 <<< (COEF_FRAC_BITS + 30), r3 * r2), 64, dummy);
    endtask

    function automatic t_kin eval_kin(logic [23:0] t);
        t_wide       pw[6];
        t_wide       acc, den;
        logic [63:0] d_out[5];
        longint      f;
        t_kin        k_out;
        logic        clip;
        clip  = 1'b0;
        den   = t_wide'(1) <<< (COEF_FRAC_BITS + 64);
        pw[0] = 1;
        for (int k = 1; k < 6; k++) pw[k] = pw[k-1] * t_wide'({232'd0, t});
        for (int d = 0; d < 5; d++) begin
            acc = 0;
            for (int k = d; k < 6; k++) begin
                f = 1;
                for (int i = 0; i < d; i++) f = f * (k - i);
                acc = acc + (((t_wide'(coef[k]) * pw[k-d]) * t_wide'(f))
                             <<< (16 * (5 - (k - d))));
            end
            d_out[d] = clamp(div_round(acc, den), 32, clip);
        end
        k_out.pos  = d_out[0][31:0];
        k_out.vel  = d_out[1][31:0];
        k_out.acc  = d_out[2][31:0];
        k_out.jrk  = d_out[3][31:0];
        k_out.snp  = d_out[4][31:0];
        k_out.clip = clip;
        return k_out;
    endfunction

    // ---------------- stimulus building ----------------
    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rnd_dur();
        logic [23:0] d;
        d = 24'($urandom) & ((24'd1 << $urandom_range(1, 24)) - 24'd1);
        return (d == '0) ? 24'd1 : d;
    endfunction

    task automatic push_solve(logic signed [31:0] sp, sv, sa, ep, ev, ea,
                              logic [23:0] dur);
        t_cmd c;
        c = '{KIND_SOLVE, sp, sv, sa, ep, ev, ea, dur, 3'($urandom),
              {$urandom, $urandom}, 24'($urandom)};
        cmd_q.push_back(c);
    endtask

    task automatic push_load(logic [2:0] idx, logic signed [63:0] val);
        t_cmd c;
        c = '{KIND_LOAD, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
              24'($urandom), idx, val, 24'($urandom)};
        cmd_q.push_back(c);
    endtask

    task automatic push_eval(logic [23:0] t);
        t_cmd c;
        c = '{KIND_EVAL, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
              24'($urandom), 3'($urandom), {$urandom, $urandom}, t};
        cmd_q.push_back(c);
    endtask

    task automatic push_noise();
        t_cmd c;
        c = '{2'd3, rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
              24'($urandom), 3'($urandom), {$urandom, $urandom}, 24'($urandom)};
        cmd_q.push_back(c);
    endtask

    task automatic build_stimulus();
        logic [23:0] dur;
        // directed: reset coefficients, extremes, ignored beats, edge durations
        push_eval(24'hff_ffff);
        push_load(3'd0, 64'sh7fff_ffff_ffff_ffff);
        push_load(3'd5, 64'sh8000_0000_0000_0000);
        push_eval(24'd0);
        push_eval(24'hff_ffff);
        push_load(3'd6, 64'sd1);        // bad index, dropped
        push_load(3'd7, -64'sd1);
        push_noise();                   // unused kind
        push_eval(24'h01_0000);
        for (int i = 0; i < 6; i++) push_load(3'(i), 64'sd0);
        push_solve(32'sh0001_0000, 0, 0, 32'sh0005_0000, 0, 0, 24'd0);  // ignored
        push_eval(24'h00_8000);
        push_solve(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 24'd1);
        push_eval(24'd1);
        push_solve(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 24'hff_ffff);
        push_eval(24'h7f_ffff);
        push_solve(0, 32'sh0001_0000, 0, 32'sh000a_0000, 0, 0, 24'h02_0000);
        push_eval(24'h01_0000);
        push_eval(24'h02_0000);
        // random: mostly solve-then-sample segments, some loads and noise
        while (cmd_q.size() < 2000) begin
            case ($urandom_range(0, 9))
                0: push_load(3'($urandom_range(0, 7)), {$urandom, $urandom});
                1: push_noise();
                2: begin
                    push_solve(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(),
                               ($urandom_range(0, 3) == 0) ? 24'd0 : rnd_dur());
                    push_eval(24'($urandom));
                end
                default: begin
                    dur = rnd_dur();
                    push_solve(rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), rnd32(), dur);
                    repeat ($urandom_range(1, 3))
                        push_eval(($urandom_range(0, 4) == 0) ? 24'($urandom)
                                  : 24'($urandom_range(0, dur)));
                end
            endcase
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                n_beats++;
                case (cur.kind)
                    KIND_SOLVE: begin
                        n_solve++;
                        solve_coefs(cur);
                    end
                    KIND_LOAD: begin
                        n_load++;
                        if (cur.idx < NUM_COEF) coef[cur.idx] = cur.val;
                    end
                    KIND_EVAL: begin
                        n_eval++;
                        kin_q.push_back(eval_kin(cur.tsamp));
                    end
                    default: ;
                endcase
            end
            // phases: none, sender idle 73%, none, sender idle 16%
            idle_pct = (n_beats < 500) ? 0 : (n_beats < 1000) ? 73 :
                       (n_beats < 1500) ? 0 : 16;
            if (!(start && busy)) begin
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur = cmd_q.pop_front();
                    start          <= 1'b1;
                    i_kind         <= cur.kind;
                    i_start_pos    <= cur.spos;
                    i_start_vel    <= cur.svel;
                    i_start_acc    <= cur.sacc;
                    i_end_pos      <= cur.epos;
                    i_end_vel      <= cur.evel;
                    i_end_acc      <= cur.eacc;
                    i_duration     <= cur.dur;
                    i_coef_index   <= cur.idx;
                    i_coef_value   <= cur.val;
                    i_sample_time  <= cur.tsamp;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor and watchdog ----------------
    always @(posedge i_clk) begin
        t_kin e;
        if (i_rst_n) begin
            quiet = (o_valid || (start && !busy)) ? 0 : quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG);
                $display("end of test: mismatches");
                $finish;
            end
            if (o_valid) begin
                if (kin_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result beat at %0t", $time);
                end else begin
                    e = kin_q.pop_front();
                    if (o_clipped) n_clip++;
                    if (o_position !== e.pos || o_velocity !== e.vel ||
                        o_acceleration !== e.acc || o_jerk !== e.jrk ||
                        o_snap !== e.snp || o_clipped !== e.clip) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"result mismatch at %0t exp %h %h %h %h %h %b",
                                      " got %h %h %h %h %h %b"},
                                     $time, e.pos, e.vel, e.acc, e.jrk, e.snp, e.clip,
                                     o_position, o_velocity, o_acceleration, o_jerk,
                                     o_snap, o_clipped);
                    end
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        start = 1'b0; i_kind = '0; i_start_pos = '0; i_start_vel = '0;
        i_start_acc = '0; i_end_pos = '0; i_end_vel = '0; i_end_acc = '0;
        i_duration = '0; i_coef_index = '0; i_coef_value = '0; i_sample_time = '0;
        i_rst_n = 1'b0;
        n_beats = 0; n_solve = 0; n_load = 0; n_eval = 0; n_clip = 0; n_bad = 0;
        quiet = 0; idle_pct = 0;
        for (int i = 0; i < 6; i++) coef[i] = '0;
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drain: every beat taken, every result back, then block settles
        wait (cmd_q.size() == 0 && !start);
        wait (kin_q.size() == 0);
        repeat (2000) @(posedge i_clk);
        if (kin_q.size() != 0) n_bad += kin_q.size();
        $display("covered %0d beats: %0d solve, %0d load, %0d evaluate (%0d clipped)",
                 n_beats, n_solve, n_load, n_eval, n_clip);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d failures", n_bad);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qtg_pkg.sv
rtl/qtg_alu.sv
rtl/quintic_trajectory_generator.sv
dv/quintic_trajectory_generator_tb.sv
